// ===== hdl/stalr_pkg.sv =====
// Package: shared types and constants for the STA/LTA ratio core.
`timescale 1ns / 1ps
`default_nettype none
package stalr_pkg;
  localparam int SampleW = 24;
  localparam int MagW    = 23;
  localparam int ShortW  = 31;
  localparam int LongW   = 35;
  localparam int RatioW  = 16;
  localparam int CfgW    = 13;
  localparam int CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_STA_LENGTH = 2'd0,
    REG_LTA_LENGTH = 2'd1,
    REG_CHANNEL_ENABLE = 2'd2,
    REG_UNUSED = 2'd3
  } cfg_reg_t;

  localparam logic [8:0]  StaReset = 9'd32;
  localparam logic [12:0] LtaReset = 13'd1024;
  localparam logic [2:0]  EnaReset = 3'd7;
  localparam logic [RatioW-1:0] RatioOne = 16'd256;
  localparam logic [RatioW-1:0] RatioMax = 16'hFFFF;

  typedef struct packed {
    logic signed [SampleW-1:0] sample_x;
    logic signed [SampleW-1:0] sample_y;
    logic signed [SampleW-1:0] sample_z;
    logic                      history_ready;
  } in_word_t;

  typedef struct packed {
    logic [RatioW-1:0] ratio_x;
    logic [RatioW-1:0] ratio_y;
    logic [RatioW-1:0] ratio_z;
    logic [RatioW-1:0] ratio_combined;
    logic              no_channel_error;
  } out_word_t;

  // magnitude of a two's complement sample, most negative saturates
  function automatic logic [MagW-1:0] mag_of(input logic [SampleW-1:0] v);
    logic [SampleW-1:0] n;
    n = v[SampleW-1] ? (~v + 1'b1) : v;
    if (n[SampleW-1]) begin
      return {MagW{1'b1}};
    end
    return n[MagW-1:0];
  endfunction
endpackage
`default_nettype wire

// ===== hdl/stalr_if.sv =====
// Interfaces: valid/ready channels for input and result words.
`timescale 1ns / 1ps
`default_nettype none
interface stalr_in_if;
  import stalr_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface stalr_out_if;
  import stalr_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/three_axis_sta_lta_ratio_core.sv =====
// Top level: three-axis STA/LTA ratio core.
// Per word: a write step, then per channel three history reads, a setup step and a run
// of a shared 64-bit serial divider, then a mean step; with no channel enabled the word
// goes straight to a flag result. A new word is taken only once the result is accepted.
// Reset: synchronous active high; histories are swept to zero (no words accepted),
// sums, pointer and registers return to reset values.
`timescale 1ns / 1ps
`default_nettype none
module three_axis_sta_lta_ratio_core #(
  parameter int MAX_SHORT = 256,
  parameter int MAX_LONG  = 4096
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [stalr_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [stalr_pkg::CfgW-1:0]    cfg_data,
  stalr_in_if.sink                       in_ch,
  stalr_out_if.source                    out_ch
);
  import stalr_pkg::*;

  localparam int Depth = MAX_SHORT + MAX_LONG;
  localparam int AW    = $clog2(Depth);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_WRITE = 8'b00000100,
    S_RD    = 8'b00001000,
    S_SUM   = 8'b00010000,
    S_DIV   = 8'b00100000,
    S_MEAN  = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  state_t state;
  logic [8:0]  sta_length;
  logic [12:0] lta_length;
  logic [2:0]  channel_enable;

  logic [MagW-1:0] hist [3][Depth];
  logic [MagW-1:0] rd_data [3];
  logic [AW-1:0] rd_addr, wr_pos, clr_addr;
  logic [1:0]  rd_step;
  logic [1:0]  ch;
  logic [MagW-1:0] old_s, new_l, old_l;
  logic [ShortW-1:0] ssum [3];
  logic [LongW-1:0]  lsum [3];
  in_word_t  inw;
  out_word_t res;
  logic [RatioW-1:0] ratio [3];
  logic [17:0] total;
  logic [8:0]  s_eff;
  logic [12:0] l_eff;
  logic [AW:0] off;
  logic [AW:0] addr_w;
  logic        div_start, div_done;
  logic [15:0] div_q;
  logic [63:0] num, den;
  logic [ShortW-1:0] st_n;
  logic [LongW-1:0]  lt_n;
  logic [MagW-1:0] cur_mag;
  logic [1:0] cnt;

  // effective lengths
  always_comb begin
    s_eff = (sta_length == 9'd0) ? 9'd1 : sta_length;
    if (32'(s_eff) > MAX_SHORT) s_eff = 9'(MAX_SHORT);
    l_eff = (lta_length == 13'd0) ? 13'd1 : lta_length;
    if (32'(l_eff) > MAX_LONG) l_eff = 13'(MAX_LONG);
  end

  // back offset for the read step
  always_comb begin
    unique case (rd_step)
      2'd0:    off = (AW+1)'(s_eff);
      2'd1:    off = (AW+1)'(s_eff - 9'd1);
      default: off = (AW+1)'(32'(s_eff) + 32'(l_eff) - 1);
    endcase
    addr_w = {1'b0, wr_pos} + (AW+1)'(Depth) - off;
    if (addr_w >= (AW+1)'(Depth)) addr_w = addr_w - (AW+1)'(Depth);
  end

  always_comb begin
    unique case (ch)
      2'd0:    cur_mag = mag_of(inw.sample_x);
      2'd1:    cur_mag = mag_of(inw.sample_y);
      default: cur_mag = mag_of(inw.sample_z);
    endcase
  end

  assign st_n = ssum[ch] + ShortW'(cur_mag) - ShortW'(old_s);
  assign lt_n = lsum[ch] + LongW'(new_l) - LongW'(old_l);
  assign num  = 64'({lt_n == '0 ? ShortW'(0) : st_n}) * 64'(l_eff) << 8;
  assign den  = 64'(lt_n) * 64'(s_eff);

  // history memories
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      if (state == S_CLEAR) begin
        hist[c][clr_addr] <= '0;
      end else if (state == S_WRITE) begin
        hist[c][wr_pos] <= (c == 0) ? mag_of(inw.sample_x) :
                           (c == 1) ? mag_of(inw.sample_y) : mag_of(inw.sample_z);
      end
      rd_data[c] <= hist[c][rd_addr];
    end
  end

  assign rd_addr = addr_w[AW-1:0];

  stalr_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(num), .den(den),
    .done(div_done), .quo(div_q)
  );

  assign in_ch.ready  = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.data  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      wr_pos <= '0;
      sta_length <= StaReset;
      lta_length <= LtaReset;
      channel_enable <= EnaReset;
      for (int c = 0; c < 3; c++) begin
        ssum[c] <= '0;
        lsum[c] <= '0;
      end
      div_start <= 1'b0;
      rd_step <= '0;
      ch <= '0;
    end else begin
      div_start <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_STA_LENGTH:     sta_length <= cfg_data[8:0];
          REG_LTA_LENGTH:     lta_length <= cfg_data;
          REG_CHANNEL_ENABLE: channel_enable <= cfg_data[2:0];
          default: ;
        endcase
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (32'(clr_addr) == Depth - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            inw <= in_ch.data;
            if (channel_enable == 3'd0) begin
              res <= '{default: '0, no_channel_error: 1'b1};
              state <= S_OUT;
            end else begin
              state <= S_WRITE;
            end
          end
        end
        S_WRITE: begin
          ch <= '0;
          rd_step <= '0;
          total <= '0;
          cnt <= '0;
          state <= S_RD;
        end
        // three reads: old short, entering long, leaving long (read data is registered)
        S_RD: begin
          if (rd_step == 2'd1) old_s <= rd_data[ch];
          if (rd_step == 2'd2) new_l <= rd_data[ch];
          if (rd_step == 2'd3) begin
            old_l <= rd_data[ch];
            state <= S_SUM;
          end
          rd_step <= rd_step + 2'd1;
        end
        S_SUM: begin
          div_start <= 1'b1;
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            ssum[ch] <= st_n;
            lsum[ch] <= lt_n;
            ratio[ch] <= (!inw.history_ready || lt_n == '0) ? RatioOne : div_q;
            if (channel_enable[ch]) begin
              total <= total + 18'((!inw.history_ready || lt_n == '0) ? RatioOne : div_q);
              cnt <= cnt + 2'd1;
            end
            if (ch == 2'd2) begin
              state <= S_MEAN;
              wr_pos <= (32'(wr_pos) == Depth - 1) ? '0 : wr_pos + 1'b1;
              res.ratio_x <= ratio[0];
              res.ratio_y <= ratio[1];
              res.ratio_z <= (!inw.history_ready || lt_n == '0) ? RatioOne : div_q;
              res.no_channel_error <= 1'b0;
            end else begin
              ch <= ch + 2'd1;
              rd_step <= '0;
              state <= S_RD;
            end
          end
        end
        // mean of enabled ratios; divide by three through a reciprocal multiply
        S_MEAN: begin
          unique case (cnt)
            2'd1:    res.ratio_combined <= total[15:0];
            2'd2:    res.ratio_combined <= total[16:1];
            default: res.ratio_combined <= 16'((36'(total) * 36'd174763) >> 19);
          endcase
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ch.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !in_ch.ready) else $error("ready during clear");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid)) else $error("ready while result pending");
endmodule
`default_nettype wire

// ===== hdl/stalr_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle, saturating.
`timescale 1ns / 1ps
`default_nettype none
module stalr_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] num,
  input  wire logic [63:0] den,
  output logic             done,
  output logic [15:0]      quo
);
  import stalr_pkg::*;

  logic [63:0] rem;
  logic [63:0] dreg;
  logic [63:0] nsh;
  logic [15:0] q;
  logic [6:0]  cnt;
  logic        busy;
  logic        sat;
  logic [64:0] trial;

  // quotient bits above 16 only flag saturation; compute 64 bits serially
  assign trial = {rem, nsh[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
        rem  <= '0;
        nsh  <= num;
        dreg <= den;
        q    <= '0;
        sat  <= 1'b0;
      end else if (busy) begin
        nsh <= {nsh[62:0], 1'b0};
        if (trial >= {1'b0, dreg}) begin
          rem <= 64'(trial - {1'b0, dreg});
          if (cnt > 7'd16) begin
            sat <= 1'b1;
          end
          q <= {q[14:0], 1'b1};
        end else begin
          rem <= trial[63:0];
          q <= {q[14:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = sat ? RatioMax : q;
endmodule
`default_nettype wire
